>>> sv/sbl_pkg.sv
`timescale 1ns / 1ps

package sbl_pkg;

    localparam int PIX_W  = 24;
    localparam int CH_W   = 8;
    localparam int N_CH   = 3;
    localparam int ENT_W  = PIX_W + 1;   // stored slot: {pixel flag, pixel}
    localparam int WIN_N  = 9;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam logic        CFG_WIDTH  = 1'b0;
    localparam logic        CFG_HEIGHT = 1'b1;
    localparam logic [11:0] WIDTH_RESET  = 12'd640;
    localparam logic [15:0] HEIGHT_RESET = 16'd480;

    localparam logic [20:0]     SAT_LIMIT = 21'd65280;
    localparam logic [CH_W-1:0] CH_MAX    = 8'd255;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic                  last;
        logic [WIN_N-1:0][PIX_W-1:0] win;
    } t_job;

endpackage

>>> sv/sbl_fifo.sv
`timescale 1ns / 1ps

module sbl_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sbl_pkg::t_job i_job,
    input  logic          i_pop,
    output sbl_pkg::t_job o_job,
    output logic          o_full,
    output logic          o_empty
);

    sbl_pkg::t_job                r_mem [sbl_pkg::Q_DEPTH];
    logic [sbl_pkg::Q_AW-1:0]     r_wr;
    logic [sbl_pkg::Q_AW-1:0]     r_rd;
    logic [sbl_pkg::Q_AW:0]       r_cnt;

    assign o_full  = (r_cnt == (sbl_pkg::Q_AW + 1)'(sbl_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

endmodule

>>> sv/sbl_front.sv
`timescale 1ns / 1ps

module sbl_front #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]   i_w,
    input  logic [15:0]                      i_h,
    input  logic                             i_cfg_we,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_drain,
    input  sbl_pkg::t_pix                    i_pix,
    input  logic                             i_full,
    output logic                             o_push,
    output sbl_pkg::t_job                    o_job
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int CAP = 2 * MAX_WIDTH + 3;
    localparam int AW  = $clog2(CAP);
    localparam int DEPTH = 2 ** AW;
    localparam int EW  = sbl_pkg::ENT_W;

    logic [EW-1:0] r_mem [DEPTH];
    logic [EW-1:0] r_rda;
    logic [EW-1:0] r_rdb;
    logic [EW-1:0] r_b_ent;
    logic [EW-1:0] r_col [2][3];     // [0]: one slot back, [1]: two slots back

    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_fill;
    logic [AW-1:0] r_dage;           // age of the most recent consumed centre
    logic          r_b_valid;
    logic          r_stale;
    logic [1:0]    r_rc;
    logic [15:0]   r_orow;
    logic [CW-1:0] r_ocol;

    logic          acc;
    logic [EW-1:0] ent_in;
    logic [AW-1:0] age_w, age_2w, age_w1, ptr_m1, dplus;
    logic [AW-1:0] addr_a, addr_b;
    logic [EW-1:0] newcol [3];
    logic          produce;
    logic [2:0]    row_ok, col_ok;
    logic [31:0]   orow32, ocol32, h32, w32;
    logic [31:0]   ocol_inc, orow_inc;

    assign o_ready = !r_stale && !r_b_valid && !i_full;
    assign acc     = i_valid && o_ready;
    assign ent_in  = i_drain ? '0 : {1'b1, i_pix};

    assign age_w  = AW'(i_w);
    assign age_2w = AW'({i_w, 1'b0});
    assign age_w1 = age_w + 1'b1;
    assign ptr_m1 = r_wptr - 1'b1;
    assign dplus  = (r_dage == AW'(CAP)) ? AW'(CAP) : r_dage + 1'b1;

    // reload reads three slot pairs from the state before the next push
    always_comb begin
        addr_a = r_wptr - age_w;
        addr_b = r_wptr - age_2w;
        if (r_stale) begin
            unique case (r_rc)
                2'd0: begin
                    addr_a = ptr_m1;
                    addr_b = ptr_m1 - age_w;
                end
                2'd1: begin
                    addr_a = ptr_m1 - age_2w;
                    addr_b = ptr_m1 - 1'b1;
                end
                2'd2: begin
                    addr_a = ptr_m1 - age_w1;
                    addr_b = ptr_m1 - age_2w - 1'b1;
                end
                default: begin
                    addr_a = ptr_m1;
                    addr_b = ptr_m1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_mem[r_wptr] <= ent_in;
        r_rda <= r_mem[addr_a];
        r_rdb <= r_mem[addr_b];
    end

    assign newcol[0] = r_b_ent;
    assign newcol[1] = r_rda;
    assign newcol[2] = r_rdb;

    assign produce = r_col[0][1][EW-1] && (age_w1 < r_fill) && (age_w1 < dplus);

    assign orow32 = 32'(r_orow);
    assign ocol32 = 32'(r_ocol);
    assign h32    = 32'(i_h);
    assign w32    = 32'(i_w);

    assign row_ok[0] = (orow32 != 32'd0) && (orow32 - 32'd1 < h32);
    assign row_ok[1] = (orow32 < h32);
    assign row_ok[2] = (orow32 + 32'd1 < h32);
    assign col_ok[0] = (ocol32 != 32'd0) && (ocol32 - 32'd1 < w32);
    assign col_ok[1] = (ocol32 < w32);
    assign col_ok[2] = (ocol32 + 32'd1 < w32);

    // row above sits two lines back, column to the left one slot further back
    always_comb begin
        o_job.last = (orow32 == h32 - 32'd1) && (ocol32 == w32 - 32'd1);
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (!(row_ok[r] && col_ok[c])) begin
                    o_job.win[r*3 + c] = '0;
                end else if (c == 2) begin
                    o_job.win[r*3 + c] = newcol[2-r][sbl_pkg::PIX_W-1:0];
                end else begin
                    o_job.win[r*3 + c] = r_col[1-c][2-r][sbl_pkg::PIX_W-1:0];
                end
            end
        end
    end

    assign o_push   = r_b_valid && produce;
    assign ocol_inc = ocol32 + 32'd1;
    assign orow_inc = orow32 + 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr    <= '0;
            r_fill    <= '0;
            r_dage    <= AW'(CAP);
            r_b_valid <= 1'b0;
            r_stale   <= 1'b0;
            r_rc      <= '0;
            r_orow    <= '0;
            r_ocol    <= '0;
        end else begin
            r_b_valid <= acc;
            if (acc) begin
                r_wptr <= r_wptr + 1'b1;
                if (r_fill != AW'(CAP)) r_fill <= r_fill + 1'b1;
            end
            if (r_b_valid) begin
                r_dage <= produce ? age_w1 : dplus;
                if (produce) begin
                    if (ocol_inc >= w32) begin
                        r_ocol <= '0;
                        r_orow <= (orow_inc >= h32) ? 16'd0 : orow_inc[15:0];
                    end else begin
                        r_ocol <= ocol_inc[CW-1:0];
                    end
                end
            end
            if (i_cfg_we) begin
                r_stale <= 1'b1;
                r_rc    <= '0;
            end else if (r_stale) begin
                r_rc <= r_rc + 1'b1;
                if (r_rc == 2'd3) r_stale <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_b_ent <= ent_in;
        if (r_b_valid) begin
            r_col[1] <= r_col[0];
            r_col[0] <= newcol;
        end else if (r_stale) begin
            unique case (r_rc)
                2'd1: begin
                    r_col[0][0] <= r_rda;
                    r_col[0][1] <= r_rdb;
                end
                2'd2: begin
                    r_col[0][2] <= r_rda;
                    r_col[1][0] <= r_rdb;
                end
                2'd3: begin
                    r_col[1][1] <= r_rda;
                    r_col[1][2] <= r_rdb;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> sv/sbl_back.sv
`timescale 1ns / 1ps

module sbl_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sbl_pkg::t_job        i_job,
    input  logic                 i_empty,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output sbl_pkg::t_pix        o_data,
    output logic                 o_last
);

    typedef enum logic [1:0] {S_IDLE, S_SQ, S_ROOT, S_FIN} t_state;

    t_state             r_state;
    logic [1:0]         r_cnt;
    logic               r_lst;
    logic signed [10:0] r_gx  [3];
    logic signed [10:0] r_gy  [3];
    logic [15:0]        r_rad [3];
    logic               r_sat [3];
    logic [7:0]         r_q   [3];
    logic [11:0]        r_rem [3];

    logic signed [10:0] gx_c  [3];
    logic signed [10:0] gy_c  [3];
    logic signed [21:0] sq_c  [3];
    logic [7:0]         q_c   [3];
    logic [11:0]        rem_c [3];
    logic [7:0]         res_c [3];

    function automatic logic signed [10:0] px(input sbl_pkg::t_job j, input int k,
                                              input int ch);
        return $signed({3'b000, j.win[k][ch*8 +: 8]});
    endfunction

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            gx_c[ch] = px(i_job, 2, ch) + (px(i_job, 5, ch) <<< 1) + px(i_job, 8, ch)
                     - px(i_job, 0, ch) - (px(i_job, 3, ch) <<< 1) - px(i_job, 6, ch);
            gy_c[ch] = px(i_job, 6, ch) + (px(i_job, 7, ch) <<< 1) + px(i_job, 8, ch)
                     - px(i_job, 0, ch) - (px(i_job, 1, ch) <<< 1) - px(i_job, 2, ch);
            sq_c[ch] = 22'(r_gx[ch]) * 22'(r_gx[ch]) + 22'(r_gy[ch]) * 22'(r_gy[ch]);
        end
    end

    // two digits of the restoring root per cycle
    always_comb begin
        logic [11:0] rn;
        logic [11:0] tr;
        logic [7:0]  q;
        logic [11:0] rm;
        for (int ch = 0; ch < 3; ch++) begin
            q  = r_q[ch];
            rm = r_rem[ch];
            for (int s = 0; s < 2; s++) begin
                rn = {rm[9:0], r_rad[ch][15-2*s -: 2]};
                tr = {2'b00, q, 2'b01};
                if (rn >= tr) begin
                    rm = rn - tr;
                    q  = {q[6:0], 1'b1};
                end else begin
                    rm = rn;
                    q  = {q[6:0], 1'b0};
                end
            end
            q_c[ch]   = q;
            rem_c[ch] = rm;
            res_c[ch] = r_sat[ch] ? sbl_pkg::CH_MAX
                                  : r_q[ch] + 8'(r_rem[ch] > {4'b0000, r_q[ch]});
        end
    end

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready && r_state != S_FIN) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_gx    <= gx_c;
                        r_gy    <= gy_c;
                        r_lst   <= i_job.last;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    for (int ch = 0; ch < 3; ch++) begin
                        r_sat[ch] <= sq_c[ch][20:0] > sbl_pkg::SAT_LIMIT;
                        r_rad[ch] <= sq_c[ch][15:0];
                        r_q[ch]   <= '0;
                        r_rem[ch] <= '0;
                    end
                    r_cnt   <= '0;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    for (int ch = 0; ch < 3; ch++) begin
                        r_q[ch]   <= q_c[ch];
                        r_rem[ch] <= rem_c[ch];
                        r_rad[ch] <= {r_rad[ch][11:0], 4'b0000};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 2'd3) r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!o_valid || i_ready) begin
                        o_valid <= 1'b1;
                        o_data  <= {res_c[2], res_c[1], res_c[0]};
                        o_last  <= r_lst;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> sv/sobel_edge_magnitude_rgb.sv
`timescale 1ns / 1ps
// Front takes no new request while the previous one is still being placed, or while the result queue is full.
// Back handles one result at a time (gradients, squares, root steps, output) and pops the
// next request from the queue only after the previous result has been output.
// A result passes through the front window, the result queue and the back states in turn.
// After a configuration write the front reloads its window before it takes new requests.
// Synchronous active-low reset; line store contents are not cleared.

module sobel_edge_magnitude_rgb #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // red_in, green_in, blue_in
    input  logic        i_s_axis_tuser,   // req_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // red_edge, green_edge, blue_edge
    output logic        o_m_axis_tlast
);

    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [11:0]   r_fw;
    logic [15:0]   r_fh;
    logic          cfg_we;
    logic [31:0]   w32;
    logic [WW-1:0] eff_w;
    logic [15:0]   eff_h;

    logic          push, pop, full, empty;
    sbl_pkg::t_job job_in, job_out;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= sbl_pkg::WIDTH_RESET;
            r_fh <= sbl_pkg::HEIGHT_RESET;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                sbl_pkg::CFG_WIDTH:  r_fw <= i_cfg_data[11:0];
                sbl_pkg::CFG_HEIGHT: r_fh <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_fw == '0)                  w32 = 32'd1;
        else if (32'(r_fw) > MAX_WIDTH)  w32 = 32'(MAX_WIDTH);
        else                             w32 = 32'(r_fw);
    end
    assign eff_w = w32[WW-1:0];
    assign eff_h = (r_fh == '0) ? 16'd1 : r_fh;

    sbl_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_w      (eff_w),
        .i_h      (eff_h),
        .i_cfg_we (cfg_we),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_drain  (i_s_axis_tuser),
        .i_pix    (i_s_axis_tdata),
        .i_full   (full),
        .o_push   (push),
        .o_job    (job_in)
    );

    sbl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_full  (full),
        .o_empty (empty)
    );

    sbl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job_out),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

endmodule
